[rtl/ecpd_pkg.sv]
// ecpd_pkg: shared types and constants of the secp256k1 key parser
`default_nettype none
package ecpd_pkg;

    localparam int FE_W = 256;

    localparam logic [FE_W-1:0] FIELD_P =
        256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
    // (p + 1) / 4
    localparam logic [FE_W-1:0] ROOT_EXP =
        256'h3FFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_BFFFFF0C;

    localparam logic [7:0] PFX_EVEN   = 8'h02;
    localparam logic [7:0] PFX_ODD    = 8'h03;
    localparam logic [7:0] PFX_FULL   = 8'h04;
    localparam logic [7:0] PFX_HYB_EV = 8'h06;
    localparam logic [7:0] PFX_HYB_OD = 8'h07;

    localparam logic [6:0] KEY_SHORT = 7'd33;
    localparam logic [6:0] KEY_LONG  = 7'd65;
    localparam logic [7:0] CURVE_B   = 8'd7;

    typedef enum logic [3:0] {
        S_LOAD, S_CHECK, S_X2, S_X3, S_ADD7,
        S_POW_SQ, S_POW_MUL, S_VERIFY, S_CMP, S_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_sts;

endpackage
`default_nettype wire

[rtl/ecpd_modmul.sv]
// ecpd_modmul: bit-serial interleaved multiplier modulo p
`default_nettype none
module ecpd_modmul
    import ecpd_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [FE_W-1:0] i_a,
    input  wire logic [FE_W-1:0] i_b,
    output t_mul_sts             o_sts,
    output logic      [FE_W-1:0] o_prod
);
    logic [FE_W-1:0] r_a, r_b, r_r;
    logic [8:0]      r_cnt;
    logic            r_busy, r_done;
    logic [FE_W+1:0] t;
    logic [FE_W+2:0] d1, d2;
    logic [FE_W-1:0] n_r;

    // r = 2r + bit*a, then at most two subtractions of p
    always_comb begin
        t  = {1'b0, r_r, 1'b0} + (r_b[FE_W-1] ? {2'b00, r_a} : '0);
        d1 = {1'b0, t} - {3'b000, FIELD_P};
        d2 = {1'b0, t} - {2'b00, FIELD_P, 1'b0};
        if (!d2[FE_W+2]) begin
            n_r = d2[FE_W-1:0];
        end else if (!d1[FE_W+2]) begin
            n_r = d1[FE_W-1:0];
        end else begin
            n_r = t[FE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 9'd256;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 9'd1;
                if (r_cnt == 9'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_r <= '0;
        end else if (r_busy) begin
            r_r <= n_r;
            r_b <= {r_b[FE_W-2:0], 1'b0};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_r;
endmodule
`default_nettype wire

[rtl/ec_pubkey_parse_decompress_unit.sv]
// ec_pubkey_parse_decompress_unit: sec1 secp256k1 key parser with point decompression
`default_nettype none
// Takes an encoded key one byte a beat (tlast on the last byte) and answers each
// key with eight 64-bit beats: X then Y, most significant word first, tuser[0]
// high when the key is valid and on the curve (all-zero words otherwise), tlast
// on the eighth beat. Bytes are taken one a cycle. All field multiplications run
// through one bit-serial modular multiplier. An uncompressed or hybrid key
// needs three multiplications; a compressed key adds the square root, a fixed
// exponentiation of 256 squarings and about 250 multiplications. The input is
// not ready from the last byte of a key until its eighth result beat is taken;
// wrong lengths and prefixes are answered straight from the check state, with
// no multiplication.
module ec_pubkey_parse_decompress_unit
    import ecpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] key_byte
    input  wire logic        i_s_axis_tlast,   // final_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata,   // [63:0] coord_word
    output logic [0:0]       o_m_axis_tuser,   // [0] parse_ok
    output logic             o_m_axis_tlast    // last_word
);
    t_state          r_state, n_state;
    logic [6:0]      r_count;
    logic            r_over, r_issued, r_ok, r_long;
    logic [7:0]      r_pre, r_bit;
    logic [2:0]      r_wcnt;
    logic [FE_W-1:0] r_x, r_y, r_rhs;

    logic            in_acc, out_acc;
    logic            x_ok, y_ok, short_ok, long_ok, mul_state, mul_start;
    logic [FE_W-1:0] mul_a, mul_b, prod;
    t_mul_sts        mul_sts;
    logic [FE_W:0]   sum7, sum7_red;
    logic [FE_W-1:0] y_neg;
    logic            par_odd, exp_bit;
    logic [2*FE_W-1:0] xy;

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // range, length and prefix checks on the collected key
    assign x_ok     = r_x < FIELD_P;
    assign y_ok     = r_y < FIELD_P;
    assign short_ok = !r_over && r_count == KEY_SHORT && x_ok &&
                      (r_pre == PFX_EVEN || r_pre == PFX_ODD);
    assign long_ok  = !r_over && r_count == KEY_LONG && x_ok && y_ok &&
                      (r_pre == PFX_FULL || r_pre == PFX_HYB_EV || r_pre == PFX_HYB_OD);

    // x^3 + b is below p + 7, so one conditional subtraction reduces it
    assign sum7     = {1'b0, r_rhs} + {{(FE_W-7){1'b0}}, CURVE_B};
    assign sum7_red = sum7 - {1'b0, FIELD_P};
    assign y_neg    = (r_y == '0) ? '0 : FIELD_P - r_y;
    assign par_odd  = r_long ? (r_pre == PFX_HYB_OD) : (r_pre == PFX_ODD);
    assign exp_bit  = ROOT_EXP[r_bit];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:    if (in_acc && i_s_axis_tlast) n_state = S_CHECK;
            S_CHECK:   n_state = (short_ok || long_ok) ? S_X2 : S_OUT;
            S_X2:      if (mul_sts.done) n_state = S_X3;
            S_X3:      if (mul_sts.done) n_state = S_ADD7;
            S_ADD7:    n_state = r_long ? S_VERIFY : S_POW_SQ;
            S_POW_SQ: begin
                if (mul_sts.done) begin
                    if (exp_bit)            n_state = S_POW_MUL;
                    else if (r_bit == 8'd0) n_state = S_VERIFY;
                end
            end
            S_POW_MUL: if (mul_sts.done) n_state = (r_bit == 8'd0) ? S_VERIFY : S_POW_SQ;
            S_VERIFY:  if (mul_sts.done) n_state = S_CMP;
            S_CMP:     n_state = S_OUT;
            S_OUT:     if (out_acc && r_wcnt == 3'd7) n_state = S_LOAD;
            default:   n_state = S_LOAD;
        endcase
    end

    // multiplier request and operand selection
    always_comb begin
        mul_state = 1'b0;
        mul_a     = r_y;
        mul_b     = r_y;
        unique case (r_state)
            S_X2:      begin mul_state = 1'b1; mul_a = r_x;   mul_b = r_x; end
            S_X3:      begin mul_state = 1'b1; mul_a = r_rhs; mul_b = r_x; end
            S_POW_SQ:  begin mul_state = 1'b1; end
            S_POW_MUL: begin mul_state = 1'b1; mul_b = r_rhs; end
            S_VERIFY:  begin mul_state = 1'b1; end
            default:   begin end
        endcase
    end

    assign mul_start       = mul_state && !r_issued;
    assign o_s_axis_tready = r_state == S_LOAD;
    assign o_m_axis_tvalid = r_state == S_OUT;
    assign xy              = {r_x, r_y};
    assign o_m_axis_tdata  = r_ok ? xy[(3'd7 - r_wcnt) * 64 +: 64] : 64'd0;
    assign o_m_axis_tuser  = r_ok;
    assign o_m_axis_tlast  = r_wcnt == 3'd7;

    ecpd_modmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_sts   (mul_sts),
        .o_prod  (prod)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_over   <= 1'b0;
            r_issued <= 1'b0;
            r_wcnt   <= '0;
        end else begin
            r_state <= n_state;
            if (mul_start)         r_issued <= 1'b1;
            else if (mul_sts.done) r_issued <= 1'b0;
            if (in_acc) begin
                if (r_count < KEY_LONG) r_count <= r_count + 7'd1;
                else                    r_over  <= 1'b1;
            end
            if (r_state == S_CHECK) begin
                r_count <= '0;
                r_over  <= 1'b0;
                r_wcnt  <= '0;
            end
            if (out_acc) r_wcnt <= r_wcnt + 3'd1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (r_count == 7'd0) begin
                r_pre <= i_s_axis_tdata;
            end else if (r_count <= KEY_SHORT - 7'd1) begin
                r_x <= {r_x[FE_W-9:0], i_s_axis_tdata};
            end else if (r_count < KEY_LONG) begin
                r_y <= {r_y[FE_W-9:0], i_s_axis_tdata};
            end
        end
        unique case (r_state)
            S_CHECK: begin
                r_ok   <= short_ok || long_ok;
                r_long <= long_ok;
            end
            S_X2, S_X3: if (mul_sts.done) r_rhs <= prod;
            S_ADD7: begin
                r_rhs <= sum7_red[FE_W] ? sum7[FE_W-1:0] : sum7_red[FE_W-1:0];
                r_bit <= 8'd255;
                if (!r_long) r_y <= {{(FE_W-1){1'b0}}, 1'b1};
            end
            S_POW_SQ: begin
                if (mul_sts.done) begin
                    r_y <= prod;
                    if (!exp_bit && r_bit != 8'd0) r_bit <= r_bit - 8'd1;
                end
            end
            S_POW_MUL: begin
                if (mul_sts.done) begin
                    r_y <= prod;
                    if (r_bit != 8'd0) r_bit <= r_bit - 8'd1;
                end
            end
            S_CMP: begin
                if (prod != r_rhs) begin
                    r_ok <= 1'b0;
                end else if (r_long) begin
                    if (r_pre != PFX_FULL && r_y[0] != par_odd) r_ok <= 1'b0;
                end else if (r_y[0] != par_odd) begin
                    r_y <= y_neg;
                end
            end
            default: begin end
        endcase
    end

    // a new multiplication is never launched over a running one
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> !mul_sts.busy)
        else $error("multiplier restarted while busy");

    // no key byte is taken while results are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input ready during result beats");

    // a rejected key reports zero words
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> o_m_axis_tdata == 64'd0)
        else $error("non-zero word on a rejected key");

    // the key length count is back at zero once results start
    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_count == 7'd0 && !r_over))
        else $error("byte count not cleared");
endmodule
`default_nettype wire

[dv/ec_pubkey_parse_decompress_unit_tb.sv]
// testbench of the secp256k1 public key parser with point decompression
`timescale 1ns / 100ps
module ec_pubkey_parse_decompress_unit_tb;
    import ecpd_pkg::*;

    typedef logic [FE_W-1:0] t_fe;
    typedef logic [7:0] t_key_q[$];

    typedef struct {
        logic [63:0] word;
        logic        ok;
        logic        last;
    } t_coord_beat;

    // no handshake on either side for this long means the block is stuck
    localparam int STALL_LIMIT = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = '0;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [63:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    ec_pubkey_parse_decompress_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),     // [7:0] key_byte
        .i_s_axis_tlast  (s_last),     // final_byte
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata), // [63:0] coord_word
        .o_m_axis_tuser  (o_m_axis_tuser), // [0] parse_ok
        .o_m_axis_tlast  (o_m_axis_tlast)  // last_word
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow of the parser state
    logic [7:0]  key_bytes [KEY_LONG];
    int          key_len;
    logic        key_overlong;
    t_coord_beat coord_expect[$];

    int  errors;
    int  bytes_sent;
    int  keys_sent;
    int  keys_good;
    int  beats_seen;
    int  hold_left;
    bit  gaps_on;
    bit  stalls_on;

    // ---------------- field arithmetic mod p ----------------

    function automatic t_fe fe_mul(t_fe a, t_fe b);
        logic [2*FE_W-1:0] prod;
        prod = {{FE_W{1'b0}}, a} * {{FE_W{1'b0}}, b};
        prod = prod % {{FE_W{1'b0}}, FIELD_P};
        return prod[FE_W-1:0];
    endfunction

    function automatic t_fe fe_pow(t_fe a, t_fe e);
        t_fe r;
        r = t_fe'(1);
        for (int i = FE_W - 1; i >= 0; i--) begin
            r = fe_mul(r, r);
            if (e[i]) r = fe_mul(r, a);
        end
        return r;
    endfunction

    // x^3 + 7
    function automatic t_fe curve_rhs(t_fe x);
        logic [FE_W:0] s;
        s = {1'b0, fe_mul(fe_mul(x, x), x)} + CURVE_B;
        if (s >= {1'b0, FIELD_P}) s = s - {1'b0, FIELD_P};
        return s[FE_W-1:0];
    endfunction

    function automatic t_fe fe_neg(t_fe y);
        return (y == '0) ? '0 : FIELD_P - y;
    endfunction

    function automatic t_fe rand_fe();
        t_fe v;
        for (int i = 0; i < 8; i++) v[32*i +: 32] = $urandom;
        return v;
    endfunction

    // random x below p that lies (or not) on the curve, y the root of it
    task automatic pick_x(input bit on_curve, output t_fe x, output t_fe y);
        t_fe rhs;
        forever begin
            x = rand_fe();
            if (x >= FIELD_P) continue;
            rhs = curve_rhs(x);
            y = fe_pow(rhs, ROOT_EXP);
            if ((fe_mul(y, y) == rhs) == on_curve) break;
        end
    endtask

    // ---------------- predictor ----------------

    function automatic t_fe key_fe(int pos);
        t_fe v;
        for (int i = 0; i < 32; i++) v[FE_W-1-8*i -: 8] = key_bytes[pos + i];
        return v;
    endfunction

    function automatic void decode_key();
        logic [7:0] pre;
        t_fe x, y, rhs;
        bit ok;
        t_coord_beat beat;
        pre = key_bytes[0];
        ok = 1'b0;
        x = '0;
        y = '0;
        if (!key_overlong && key_len == KEY_SHORT &&
            (pre == PFX_EVEN || pre == PFX_ODD)) begin
            x = key_fe(1);
            if (x < FIELD_P) begin
                rhs = curve_rhs(x);
                y = fe_pow(rhs, ROOT_EXP);
                if (fe_mul(y, y) == rhs) begin
                    ok = 1'b1;
                    if (y[0] != (pre == PFX_ODD)) y = fe_neg(y);
                end
            end
        end else if (!key_overlong && key_len == KEY_LONG &&
                     (pre == PFX_FULL || pre == PFX_HYB_EV || pre == PFX_HYB_OD)) begin
            x = key_fe(1);
            y = key_fe(33);
            if (x < FIELD_P && y < FIELD_P && fe_mul(y, y) == curve_rhs(x))
                ok = (pre == PFX_FULL) || (y[0] == (pre == PFX_HYB_OD));
        end
        if (ok) keys_good++;
        for (int k = 0; k < 8; k++) begin
            beat.word = !ok ? 64'd0 :
                        (k < 4) ? x[FE_W-1-64*k -: 64] : y[FE_W-1-64*(k-4) -: 64];
            beat.ok   = ok;
            beat.last = (k == 7);
            coord_expect.push_back(beat);
        end
    endfunction

    function automatic void track_byte(logic [7:0] b, logic fin);
        if (key_len < KEY_LONG) begin
            key_bytes[key_len] = b;
            key_len++;
        end else begin
            key_overlong = 1'b1;
        end
        if (fin) begin
            decode_key();
            key_len = 0;
            key_overlong = 1'b0;
            keys_sent++;
        end
    endfunction

    // ---------------- input side ----------------

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= fin;
        do @(posedge i_clk); while (!o_s_axis_tready);
        track_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_key(input t_key_q kb);
        foreach (kb[i]) send_byte(kb[i], i == kb.size() - 1);
    endtask

    // lowers valid and waits until every expected beat has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (coord_expect.size() != 0) @(posedge i_clk);
    endtask

    function automatic void push_fe(ref t_key_q kb, input t_fe v);
        for (int i = 31; i >= 0; i--) kb.push_back(v[8*i +: 8]);
    endfunction

    function automatic t_key_q long_key(logic [7:0] pre, t_fe x, t_fe y);
        t_key_q kb;
        kb.push_back(pre);
        push_fe(kb, x);
        push_fe(kb, y);
        return kb;
    endfunction

    function automatic t_key_q short_key(logic [7:0] pre, t_fe x);
        t_key_q kb;
        kb.push_back(pre);
        push_fe(kb, x);
        return kb;
    endfunction

    // random bytes of any length but 33, so that no square root is started
    function automatic t_key_q junk_key();
        t_key_q kb;
        int n;
        do n = $urandom_range(1, 72); while (n == KEY_SHORT);
        for (int i = 0; i < n; i++) kb.push_back(8'($urandom));
        return kb;
    endfunction

    // valid full or hybrid key, now and then with a wrong parity or off the curve
    function automatic t_key_q random_long_key(t_fe x, t_fe y);
        logic [7:0] pre;
        case ($urandom_range(0, 2))
            0: pre = PFX_FULL;
            1: pre = PFX_HYB_EV;
            default: pre = PFX_HYB_OD;
        endcase
        if ($urandom_range(0, 1)) y = fe_neg(y);
        if ($urandom_range(0, 7) == 0) y = y ^ (t_fe'(1) << $urandom_range(0, 255));
        return long_key(pre, x, y);
    endfunction

    // ---------------- output side ----------------

    always @(posedge i_clk) begin
        t_coord_beat exp_beat;
        logic nxt_ready;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            beats_seen++;
            if (coord_expect.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat word=%h ok=%b last=%b", $time,
                         o_m_axis_tdata, o_m_axis_tuser[0], o_m_axis_tlast);
            end else begin
                exp_beat = coord_expect.pop_front();
                if (o_m_axis_tdata !== exp_beat.word) begin
                    errors++;
                    $display("%0t: coord_word expected %h actual %h", $time,
                             exp_beat.word, o_m_axis_tdata);
                end
                if (o_m_axis_tuser[0] !== exp_beat.ok) begin
                    errors++;
                    $display("%0t: parse_ok expected %b actual %b", $time,
                             exp_beat.ok, o_m_axis_tuser[0]);
                end
                if (o_m_axis_tlast !== exp_beat.last) begin
                    errors++;
                    $display("%0t: last_word expected %b actual %b", $time,
                             exp_beat.last, o_m_axis_tlast);
                end
            end
        end
        // ready pattern: long hold when asked, random stall bursts otherwise
        nxt_ready = 1'b1;
        if (!i_rst_n) begin
            nxt_ready = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
        end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 9);
            nxt_ready = 1'b0;
        end
        m_ready <= nxt_ready;
    end

    // watchdog on handshakes
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- tests ----------------

    task automatic test_malformed();
        t_key_q kb;
        t_fe x, y;
        send_key('{8'h00});
        send_key('{PFX_FULL});
        pick_x(1'b1, x, y);
        send_key(short_key(8'h05, x));          // bad prefix for a short key
        kb = long_key(PFX_FULL, x, y);
        kb.push_back(8'hA5);                     // one byte too many
        send_key(kb);
    endtask

    task automatic test_full_keys();
        t_fe x, y;
        pick_x(1'b1, x, y);
        send_key(long_key(PFX_FULL, x, y));
        send_key(long_key(y[0] ? PFX_HYB_EV : PFX_HYB_OD, x, y)); // parity wrong
    endtask

    // each key here with x below p runs a full square root, so there are few of them
    task automatic test_compressed();
        t_fe x, y;
        send_key(short_key(PFX_EVEN, '1));       // x not below p, rejected early
        pick_x(1'b1, x, y);
        send_key(short_key(PFX_EVEN, x));
        pick_x(1'b1, x, y);
        send_key(short_key(PFX_ODD, x));
        pick_x(1'b0, x, y);                      // no root exists
        send_key(short_key(PFX_EVEN, x));
        drain();
    endtask

    // one-byte keys are answered at once, so the hold stalls the input behind their results
    task automatic test_backpressure();
        @(negedge i_clk);
        hold_left = 400;
        @(posedge i_clk);
        for (int i = 0; i < 4; i++) send_key('{PFX_FULL});
        drain();
    endtask

    task automatic test_random(input int item_goal);
        t_fe x, y;
        int pick;
        while (bytes_sent < item_goal) begin
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
                pick_x(1'b1, x, y);
                send_key(random_long_key(x, y));
            end else begin
                send_key(junk_key());
            end
            if ($urandom_range(0, 15) == 0) drain();
        end
    endtask

    initial begin
        errors = 0;
        bytes_sent = 0;
        keys_sent = 0;
        keys_good = 0;
        beats_seen = 0;
        hold_left = 0;
        key_len = 0;
        key_overlong = 1'b0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_malformed();
        test_full_keys();
        test_compressed();
        test_backpressure();
        test_random(420);

        // last stretch without idling on either side
        drain();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        send_key(junk_key());
        drain();
        repeat (50) @(posedge i_clk);

        $display("covered %0d key bytes in %0d keys (%0d valid), %0d result beats",
                 bytes_sent, keys_sent, keys_good, beats_seen);
        $display("short, full and hybrid keys, bad lengths, prefixes and values");
        if (errors == 0 && coord_expect.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
